// ===== hw/rtl/mset_pkg.sv =====
`timescale 1ns / 1ps

package mset_pkg;

    localparam int NUM_SLOTS   = 10;
    localparam int MAX_RESULTS = 10;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int RES_W  = $clog2(MAX_RESULTS + 1);

    localparam int CNT_W = 32;
    localparam int TAG_W = 8;
    localparam int IDX_W = 6;

    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_REGISTER = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    localparam logic [2:0] KIND_REGISTERED = 3'd0;
    localparam logic [2:0] KIND_FULL       = 3'd1;
    localparam logic [2:0] KIND_FIRED      = 3'd2;
    localparam logic [2:0] KIND_IDLE       = 3'd3;
    localparam logic [2:0] KIND_CLEARED    = 3'd4;

    typedef struct packed {
        logic [1:0]       operation;
        logic [CNT_W-1:0] delay_ticks;
        logic [CNT_W-1:0] period_ticks;
        logic [TAG_W-1:0] event_tag;
    } in_item_t;

    typedef struct packed {
        logic [2:0]       result_kind;
        logic [IDX_W-1:0] slot_index;
        logic [TAG_W-1:0] fired_tag;
        logic             last;
    } out_item_t;

    // slot as seen by the shared update unit
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] period;
    } slot_state_t;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] count;
        logic             fire;
    } slot_upd_t;

endpackage

// ===== hw/rtl/multi_slot_event_timer.sv =====
`timescale 1ns / 1ps
// Register and clear give their single result, registered, in the cycle after the beat.
// Tick: slots are walked one per cycle through a shared update unit; busy stays
// high through the walk and the finish state, where the final result is registered.
// A new tick is taken only once busy is low again; register/clear one per cycle.
// Reset (rst_n low, async) empties all slots at once; no clearing pass.
// Results are one-cycle strobes; the receiver cannot stall.
module multi_slot_event_timer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  mset_pkg::in_item_t    item,
    output logic                  strobe,
    output mset_pkg::out_item_t   result
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_WALK   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [mset_pkg::NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [mset_pkg::CNT_W-1:0]     count_reg  [mset_pkg::NUM_SLOTS];
    logic [mset_pkg::CNT_W-1:0]     period_reg [mset_pkg::NUM_SLOTS];
    logic [mset_pkg::TAG_W-1:0]     tag_reg    [mset_pkg::NUM_SLOTS];

    logic [mset_pkg::SLOT_W-1:0] idx_reg, idx_next;
    logic [mset_pkg::RES_W-1:0]  rep_reg, rep_next;

    logic                        pend_reg, pend_next;
    logic [mset_pkg::SLOT_W-1:0] pend_idx_reg, pend_idx_next;
    logic [mset_pkg::TAG_W-1:0]  pend_tag_reg, pend_tag_next;

    logic                 strobe_reg, strobe_next;
    mset_pkg::out_item_t  result_reg, result_next;

    logic                        free_found;
    logic [mset_pkg::SLOT_W-1:0] free_idx;
    logic                        accept;
    logic                        do_register;
    logic                        do_walk;

    mset_pkg::slot_state_t cur;
    mset_pkg::slot_upd_t   upd;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int s = mset_pkg::NUM_SLOTS - 1; s >= 0; s--)
        begin
            if (!valid_reg[s])
            begin
                free_found = 1'b1;
                free_idx   = mset_pkg::SLOT_W'(s);
            end
        end
    end

    assign cur.valid  = valid_reg[idx_reg];
    assign cur.count  = count_reg[idx_reg];
    assign cur.period = period_reg[idx_reg];

    mset_slot_unit u_slot (
        .cur (cur),
        .upd (upd)
    );

    assign do_register = accept && (item.operation == mset_pkg::OP_REGISTER) && free_found;
    assign do_walk     = (state_reg == ST_WALK) && cur.valid;

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        idx_next      = idx_reg;
        rep_next      = rep_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        pend_tag_next = pend_tag_reg;
        strobe_next   = 1'b0;
        result_next   = result_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.operation)
                        mset_pkg::OP_TICK:
                        begin
                            idx_next   = '0;
                            rep_next   = '0;
                            pend_next  = 1'b0;
                            state_next = ST_WALK;
                        end
                        mset_pkg::OP_REGISTER:
                        begin
                            strobe_next = 1'b1;
                            result_next.fired_tag = '0;
                            result_next.last      = 1'b1;
                            if (free_found)
                            begin
                                valid_next[free_idx]    = 1'b1;
                                result_next.result_kind = mset_pkg::KIND_REGISTERED;
                                result_next.slot_index  = mset_pkg::IDX_W'(free_idx);
                            end
                            else
                            begin
                                result_next.result_kind = mset_pkg::KIND_FULL;
                                result_next.slot_index  = '0;
                            end
                        end
                        mset_pkg::OP_CLEAR:
                        begin
                            valid_next  = '0;
                            strobe_next = 1'b1;
                            result_next.result_kind = mset_pkg::KIND_CLEARED;
                            result_next.slot_index  = '0;
                            result_next.fired_tag   = '0;
                            result_next.last        = 1'b1;
                        end
                        default:
                        begin
                            // unused code: no state change, no result
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                valid_next[idx_reg] = upd.valid;
                if (upd.fire && (rep_reg < mset_pkg::RES_W'(mset_pkg::MAX_RESULTS)))
                begin
                    // a later firing proves the held one is not the last
                    if (pend_reg)
                    begin
                        strobe_next = 1'b1;
                        result_next.result_kind = mset_pkg::KIND_FIRED;
                        result_next.slot_index  = mset_pkg::IDX_W'(pend_idx_reg);
                        result_next.fired_tag   = pend_tag_reg;
                        result_next.last        = 1'b0;
                    end
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg;
                    pend_tag_next = tag_reg[idx_reg];
                    rep_next      = mset_pkg::RES_W'(rep_reg + 1'b1);
                end
                if (idx_reg == mset_pkg::SLOT_W'(mset_pkg::NUM_SLOTS - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next = mset_pkg::SLOT_W'(idx_reg + 1'b1);
                end
            end
            ST_FINISH:
            begin
                strobe_next      = 1'b1;
                result_next.last = 1'b1;
                if (pend_reg)
                begin
                    result_next.result_kind = mset_pkg::KIND_FIRED;
                    result_next.slot_index  = mset_pkg::IDX_W'(pend_idx_reg);
                    result_next.fired_tag   = pend_tag_reg;
                end
                else
                begin
                    result_next.result_kind = mset_pkg::KIND_IDLE;
                    result_next.slot_index  = '0;
                    result_next.fired_tag   = '0;
                end
                pend_next  = 1'b0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            valid_reg  <= '0;
            idx_reg    <= '0;
            rep_reg    <= '0;
            pend_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            valid_reg  <= valid_next;
            idx_reg    <= idx_next;
            rep_reg    <= rep_next;
            pend_reg   <= pend_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        pend_tag_reg <= pend_tag_next;
        result_reg   <= result_next;
        if (do_register)
        begin
            count_reg[free_idx]  <= item.delay_ticks;
            period_reg[free_idx] <= item.period_ticks;
            tag_reg[free_idx]    <= item.event_tag;
        end
        else if (do_walk)
        begin
            count_reg[idx_reg] <= upd.count;
        end
    end

endmodule

// ===== hw/rtl/mset_slot_unit.sv =====
`timescale 1ns / 1ps

// Tick update of one slot: fire on zero, reload or free, then decrement.
module mset_slot_unit (
    input  mset_pkg::slot_state_t cur,
    output mset_pkg::slot_upd_t   upd
);

    always_comb
    begin
        upd.valid = cur.valid;
        upd.count = cur.count;
        upd.fire  = 1'b0;
        if (cur.valid)
        begin
            if (cur.count == '0)
            begin
                upd.fire = 1'b1;
                if (cur.period != '0)
                begin
                    upd.count = cur.period - 1'b1;
                end
                else
                begin
                    upd.valid = 1'b0;
                end
            end
            else
            begin
                upd.count = cur.count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/mset_checker.sv =====
`timescale 1ns / 1ps

module mset_props (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input mset_pkg::in_item_t  item,
    input logic                strobe,
    input mset_pkg::out_item_t result
);

    // register beat answers on the very next cycle with a single result
    a_register_answer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.operation == mset_pkg::OP_REGISTER) |=>
        strobe && result.last &&
        ((result.result_kind == mset_pkg::KIND_REGISTERED) ||
         (result.result_kind == mset_pkg::KIND_FULL)))
        else $error("register beat without its result");

    // intermediate results only come out of a tick walk
    a_nonlast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last |-> busy &&
        (result.result_kind == mset_pkg::KIND_FIRED))
        else $error("non-final result outside a tick walk");

    // end of a walk always delivers the final result
    a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> strobe && result.last)
        else $error("tick walk ended without final result");

    a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.result_kind != mset_pkg::KIND_FIRED) |->
        (result.fired_tag == '0))
        else $error("tag set on a non-firing result");

    a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && ((result.result_kind == mset_pkg::KIND_FULL) ||
                   (result.result_kind == mset_pkg::KIND_IDLE) ||
                   (result.result_kind == mset_pkg::KIND_CLEARED)) |->
        (result.slot_index == '0))
        else $error("slot index set where not applicable");

endmodule

bind multi_slot_event_timer mset_props u_mset_props (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
);

// ===== verif/mset_checker.sv =====
`timescale 1ns / 1ps

module mset_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  mset_pkg::in_item_t  item,
    input  logic                strobe,
    input  mset_pkg::out_item_t result,
    output int                  fail_count,
    output int                  pending
);

    // shadow copy of the slot table
    logic [mset_pkg::NUM_SLOTS-1:0] slot_live;
    logic [mset_pkg::CNT_W-1:0]     count_left [mset_pkg::NUM_SLOTS];
    logic [mset_pkg::CNT_W-1:0]     reload_len [mset_pkg::NUM_SLOTS];
    logic [mset_pkg::TAG_W-1:0]     tag_of     [mset_pkg::NUM_SLOTS];

    mset_pkg::out_item_t due_results[$];
    int                  errors;

    function automatic mset_pkg::out_item_t make_result(
        input logic [2:0]               kind,
        input int                       slot,
        input logic [mset_pkg::TAG_W-1:0] tag);
        mset_pkg::out_item_t r;
        r.result_kind = kind;
        r.slot_index  = mset_pkg::IDX_W'(slot);
        r.fired_tag   = tag;
        r.last        = 1'b0;
        return r;
    endfunction

    // advance the shadow table by one beat and queue the results it causes
    function automatic void run_timer_beat(input mset_pkg::in_item_t it);
        mset_pkg::out_item_t batch [mset_pkg::MAX_RESULTS+1];
        mset_pkg::out_item_t r;
        int                  n;
        int                  free_slot;
        n = 0;
        case (it.operation)
            mset_pkg::OP_REGISTER:
            begin
                free_slot = -1;
                for (int s = 0; s < mset_pkg::NUM_SLOTS; s++)
                    if (free_slot < 0 && !slot_live[s])
                        free_slot = s;
                if (free_slot >= 0)
                begin
                    slot_live[free_slot]  = 1'b1;
                    count_left[free_slot] = it.delay_ticks;
                    reload_len[free_slot] = it.period_ticks;
                    tag_of[free_slot]     = it.event_tag;
                    batch[0] = make_result(mset_pkg::KIND_REGISTERED, free_slot, '0);
                end
                else
                    batch[0] = make_result(mset_pkg::KIND_FULL, 0, '0);
                n = 1;
            end
            mset_pkg::OP_CLEAR:
            begin
                slot_live = '0;
                batch[0]  = make_result(mset_pkg::KIND_CLEARED, 0, '0);
                n = 1;
            end
            mset_pkg::OP_TICK:
            begin
                for (int s = 0; s < mset_pkg::NUM_SLOTS; s++)
                begin
                    if (slot_live[s])
                    begin
                        if (count_left[s] == '0)
                        begin
                            // firings past the report cap still reload or free
                            if (n < mset_pkg::MAX_RESULTS)
                            begin
                                batch[n] = make_result(mset_pkg::KIND_FIRED, s, tag_of[s]);
                                n++;
                            end
                            if (reload_len[s] != '0)
                                count_left[s] = reload_len[s];
                            else
                                slot_live[s] = 1'b0;
                        end
                        if (slot_live[s])
                            count_left[s] = count_left[s] - 1'b1;
                    end
                end
                if (n == 0)
                begin
                    batch[0] = make_result(mset_pkg::KIND_IDLE, 0, '0);
                    n = 1;
                end
            end
            default: ;
        endcase
        for (int k = 0; k < n; k++)
        begin
            r      = batch[k];
            r.last = (k == n - 1);
            due_results.push_back(r);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mset_pkg::out_item_t want;
        if (!rst_n)
        begin
            slot_live = '0;
            due_results.delete();
            errors = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // a result never belongs to a beat taken at the same edge
            if (strobe)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: unexpected result kind=%0d slot=%0d tag=%0h last=%0b",
                             $time, result.result_kind, result.slot_index,
                             result.fired_tag, result.last);
                    errors++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result.result_kind !== want.result_kind ||
                        result.slot_index !== want.slot_index ||
                        result.fired_tag !== want.fired_tag ||
                        result.last !== want.last)
                    begin
                        $display("%0t: mismatch expected kind=%0d slot=%0d tag=%0h last=%0b",
                                 $time, want.result_kind, want.slot_index,
                                 want.fired_tag, want.last);
                        $display("%0t:          actual   kind=%0d slot=%0d tag=%0h last=%0b",
                                 $time, result.result_kind, result.slot_index,
                                 result.fired_tag, result.last);
                        errors++;
                    end
                end
            end
            if (start && !busy)
                run_timer_beat(item);
            fail_count <= errors;
            pending    <= due_results.size();
        end
    end

endmodule

// ===== verif/multi_slot_event_timer_test.sv =====
`timescale 1ns / 1ps

module multi_slot_event_timer_test;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int ITEM_COUNT    = 480;
    localparam int DIRECTED_BEATS = 21;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    mset_pkg::in_item_t  item;
    logic                strobe;
    mset_pkg::out_item_t result;
    int                  fail_count;
    int                  pending;
    int                  burst_left;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    multi_slot_event_timer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .strobe (strobe),
        .result (result)
    );

    mset_checker timer_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .strobe     (strobe),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    function automatic mset_pkg::in_item_t pack_item(
        input logic [1:0]                 op,
        input logic [mset_pkg::CNT_W-1:0] dly,
        input logic [mset_pkg::CNT_W-1:0] per,
        input logic [mset_pkg::TAG_W-1:0] tag);
        mset_pkg::in_item_t it;
        it.operation    = op;
        it.delay_ticks  = dly;
        it.period_ticks = per;
        it.event_tag    = tag;
        return it;
    endfunction

    // mostly short delays and periods so events actually fire; some full-range values
    function automatic mset_pkg::in_item_t random_item();
        mset_pkg::in_item_t it;
        int                 r;
        it = pack_item(mset_pkg::OP_TICK, $urandom, $urandom,
                       mset_pkg::TAG_W'($urandom_range(0, 255)));
        r  = $urandom_range(0, 99);
        if (r < 45)
            it.operation = mset_pkg::OP_TICK;
        else if (r < 88)
        begin
            it.operation = mset_pkg::OP_REGISTER;
            if ($urandom_range(0, 99) < 80)
                it.delay_ticks = $urandom_range(0, 6);
            r = $urandom_range(0, 99);
            if (r < 40)
                it.period_ticks = '0;
            else if (r < 85)
                it.period_ticks = $urandom_range(1, 5);
        end
        else if (r < 94)
            it.operation = mset_pkg::OP_CLEAR;
        else
            it.operation = OP_UNUSED;
        return it;
    endfunction

    // drive one beat, hold until taken, then maybe idle
    task automatic send_beat(input mset_pkg::in_item_t it);
        int gap;
        int r;
        item  <= it;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        r = $urandom_range(0, 99);
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else if (r < 50)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 4);
        else
            gap = $urandom_range(5, 40);
        if (r >= 97)
            burst_left = $urandom_range(10, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        mset_pkg::in_item_t it;
        int                 issued;
        int                 waited;
        burst_left = 0;
        issued     = 0;
        rst_n <= 1'b0;
        start <= 1'b0;
        item  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, ignored opcode, one-shot and max-range registers
        send_beat(pack_item(mset_pkg::OP_TICK, '0, '0, '0));
        send_beat(pack_item(OP_UNUSED, '1, '1, '1));
        send_beat(pack_item(mset_pkg::OP_REGISTER, '0, '0, 8'hFF));
        send_beat(pack_item(mset_pkg::OP_REGISTER, '1, '1, 8'h00));
        send_beat(pack_item(mset_pkg::OP_TICK, '0, '0, '0));
        send_beat(pack_item(mset_pkg::OP_CLEAR, '0, '0, '0));
        // fill the table, overflow it, then fire every slot at once
        for (int k = 0; k < mset_pkg::NUM_SLOTS; k++)
            send_beat(pack_item(mset_pkg::OP_REGISTER, '0, mset_pkg::CNT_W'(k % 2),
                                mset_pkg::TAG_W'(k * 23 + 5)));
        send_beat(pack_item(mset_pkg::OP_REGISTER, 32'd3, 32'd3, 8'hA5));
        send_beat(pack_item(mset_pkg::OP_TICK, '0, '0, '0));
        send_beat(pack_item(mset_pkg::OP_TICK, '0, '0, '0));
        send_beat(pack_item(mset_pkg::OP_CLEAR, '1, '1, '1));
        send_beat(pack_item(mset_pkg::OP_TICK, '0, '0, '0));

        while (issued < ITEM_COUNT - DIRECTED_BEATS)
        begin
            it = random_item();
            if (it.operation != OP_UNUSED)
                issued++;
            send_beat(it);
        end
        start <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (mset_pkg::NUM_SLOTS + 4) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
